// ===== hdl/tql_pkg.sv =====
// ---------------------------------------------------------------------------
// Q-learning step package
// Shared constants, types and helper functions of the Q-learning step block.
// ---------------------------------------------------------------------------
package tql_pkg;

	localparam int NUM_COORDS_DEF = 2;
	localparam int GRID_SIZE_DEF  = 4;
	localparam int MAX_DRAWS      = 8;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [16:0] ONE_Q16   = 17'd65536;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_DISCOUNT      = 3'd0;
	localparam logic [2:0] REG_LEARN_RATE    = 3'd1;
	localparam logic [2:0] REG_EXPLORE_DECAY = 3'd2;
	localparam logic [2:0] REG_EXPLORE_START = 3'd3;
	localparam logic [2:0] REG_INITIAL_VALUE = 3'd4;
	localparam logic [2:0] REG_RANDOM_SEED   = 3'd5;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EPS,
		ST_SCAN_OLD,
		ST_DRAW,
		ST_REDRAW,
		ST_MOVE,
		ST_SCAN_NEW,
		ST_MUL_LOOK,
		ST_MUL_LEARN,
		ST_WRITE,
		ST_OUT
	} tql_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear_wr;   // write the fill value at the sweep address
		logic clear_rst;  // restart the sweep address
		logic start;      // latch the performance word and start the decay multiply
		logic scan_rst;   // restart a table scan
		logic scan_step;  // take one scanned entry
		logic scan_new;   // scan at the new cell
		logic draw_grd;   // first draw: greedy test
		logic draw_rnd;   // redraw a random move
		logic do_move;    // apply the move
		logic mul_look;   // gamma product
		logic mul_learn;  // alpha product
		logic write_q;    // store new Q value and result
	} tql_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic greedy;
		logic rnd_ok;
		logic draws_done;
	} tql_stat_t;

	function automatic logic [16:0] clamp_one(input logic [16:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [31:0] lfsr_next(input logic [31:0] w);
		return w[0] ? ((w >> 1) ^ LFSR_TAPS) : (w >> 1);
	endfunction

endpackage

// ===== hdl/tql_ctrl.sv =====
// ---------------------------------------------------------------------------
// Q-learning step controller
// Sequences table clearing, scans, draws, multiplies and the table update.
// ---------------------------------------------------------------------------
module tql_ctrl
	import tql_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      refill,
	output tql_cmd_t  cmd,
	input  tql_stat_t stat
);

	tql_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (stat.clear_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (refill) state_d = ST_CLEAR;
				else if (in_valid) state_d = ST_EPS;
			end
			ST_EPS:       state_d = ST_SCAN_OLD;
			ST_SCAN_OLD:  if (stat.scan_done) state_d = ST_DRAW;
			ST_DRAW:      state_d = stat.greedy ? ST_MOVE : ST_REDRAW;
			ST_REDRAW:    if (stat.rnd_ok || stat.draws_done) state_d = ST_MOVE;
			ST_MOVE:      state_d = ST_SCAN_NEW;
			ST_SCAN_NEW:  if (stat.scan_done) state_d = ST_MUL_LOOK;
			ST_MUL_LOOK:  state_d = ST_MUL_LEARN;
			ST_MUL_LEARN: state_d = ST_WRITE;
			ST_WRITE:     state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR:     cmd.clear_wr = 1'b1;
			ST_IDLE: begin
				in_ready      = !refill;
				cmd.start     = in_valid && !refill;
				cmd.scan_rst  = 1'b1;
				cmd.clear_rst = 1'b1;
			end
			ST_EPS:       cmd.scan_rst = 1'b1;
			ST_SCAN_OLD:  cmd.scan_step = 1'b1;
			ST_DRAW:      cmd.draw_grd = 1'b1;
			ST_REDRAW:    cmd.draw_rnd = 1'b1;
			ST_MOVE: begin
				cmd.do_move  = 1'b1;
				cmd.scan_rst = 1'b1;
			end
			ST_SCAN_NEW: begin
				cmd.scan_step = 1'b1;
				cmd.scan_new  = 1'b1;
			end
			ST_MUL_LOOK:  cmd.mul_look = 1'b1;
			ST_MUL_LEARN: cmd.mul_learn = 1'b1;
			ST_WRITE:     cmd.write_q = 1'b1;
			ST_OUT:       out_valid = 1'b1;
			default:      cmd = '0;
		endcase
	end

endmodule

// ===== hdl/tql_datapath.sv =====
// ---------------------------------------------------------------------------
// Q-learning step datapath
// Holds the value table, the grid position, epsilon, the LFSR and the
// arithmetic of the update.
// ---------------------------------------------------------------------------
module tql_datapath
	import tql_pkg::*;
#(
	parameter int NUM_COORDS = NUM_COORDS_DEF,
	parameter int GRID_SIZE  = GRID_SIZE_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] performance,
	input  tql_cmd_t           cmd,
	output tql_stat_t          stat,
	output logic [2:0]         chosen_move,
	output logic [3:0]         grid_cell,
	output logic [16:0]        explore_prob,
	output logic signed [31:0] updated_value
);

	localparam int NUM_MOVES = 1 + 2 * NUM_COORDS;
	localparam int NUM_CELLS = GRID_SIZE ** NUM_COORDS;
	localparam int DEPTH     = NUM_CELLS * NUM_MOVES;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(NUM_CELLS);
	localparam int MW        = $clog2(NUM_MOVES + 1);
	localparam int KW        = $clog2(GRID_SIZE);
	localparam int DW        = $clog2(MAX_DRAWS + 1);

	// Reciprocals for the draw residues: floor(x / d) is the top bits of
	// x * ceil(2^(32+l) / d) with l = ceil(log2(d)), exact for any 32-bit x.
	localparam int LW_MV = $clog2(NUM_MOVES);
	localparam logic [32:0] RECIP_101 = 33'(((64'd1 << 39) + 64'd100) / 64'd101);
	localparam logic [32:0] RECIP_MV  = 33'(((64'd1 << (32 + LW_MV)) + 64'(NUM_MOVES)
		- 64'd1) / 64'(NUM_MOVES));
	// Word produced by the first draw after a reset with the default seed.
	localparam logic [31:0] FIRST_WORD = LFSR_TAPS;

	// Configuration registers.
	logic [16:0] discount_q, learn_rate_q, explore_decay_q, explore_start_q;
	logic signed [31:0] initial_value_q;
	logic [31:0] random_seed_q;

	// Block state.
	logic [CW-1:0] cell_q, old_cell_q;
	logic [KW-1:0] coord_q [NUM_COORDS];
	logic signed [31:0] last_perf_q, perf_q;
	logic [16:0] eps_q;
	logic [31:0] lfsr_q;

	// Working registers.
	logic [MW-1:0] scan_m_q;
	logic [MW-1:0] move_q;
	logic signed [31:0] best_q;
	logic [DW-1:0] draws_q;
	logic [AW-1:0] clr_addr_q;
	logic signed [31:0] q_old_q;
	logic signed [37:0] sample_q;
	logic signed [37:0] nq_q;
	logic [33:0] eps_prod_q;
	logic [6:0]  d101_q;
	logic [MW-1:0] cand_q;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;

	// Allowed moves at the current position.
	logic ok [NUM_MOVES];
	always_comb begin
		ok[0] = 1'b1;
		for (int k = 0; k < NUM_COORDS; k++) begin
			ok[2*k+1] = (32'(coord_q[k]) + 32'd1) < 32'(GRID_SIZE);
			ok[2*k+2] = coord_q[k] != '0;
		end
	end

	// Cell index of the current coordinates.
	logic [CW-1:0] cell_calc;
	always_comb begin
		logic [31:0] c;
		logic [31:0] stride;
		c = '0;
		stride = 32'd1;
		for (int k = 0; k < NUM_COORDS; k++) begin
			c = c + 32'(coord_q[k]) * stride;
			stride = stride * 32'(GRID_SIZE);
		end
		cell_calc = CW'(c);
	end

	// Table address: scan, update or clearing sweep. The new cell is taken
	// straight from the coordinates so that its first entry is read in time.
	logic [CW-1:0] base_cell;
	logic [AW-1:0] rd_addr, wr_addr;
	assign base_cell = cmd.scan_new ? cell_calc : old_cell_q;
	assign rd_addr = AW'(32'(base_cell) * NUM_MOVES + 32'(scan_m_q));
	assign wr_addr = AW'(32'(old_cell_q) * NUM_MOVES + 32'(move_q));

	// Table memory with registered read.
	logic signed [31:0] nq_sat;
	assign nq_sat = (nq_q > 38'sd2147483647) ? 32'sh7fffffff :
		(nq_q < -38'sd2147483648) ? 32'sh80000000 : nq_q[31:0];
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) mem[clr_addr_q] <= initial_value_q;
		else if (cmd.write_q) mem[wr_addr] <= nq_sat;
		rd_q <= mem[rd_addr];
	end

	// Rounded Q22.16 by Q1.16 product, ties toward plus infinity.
	function automatic logic signed [37:0] mulr(input logic signed [37:0] a,
		input logic [16:0] w);
		logic signed [55:0] x;
		x = 56'(a) * $signed({1'b0, w}) + 56'sd32768;
		return 38'(x >>> 16);
	endfunction

	// Remainder of a word by 101 through a reciprocal multiply.
	function automatic logic [6:0] mod_101(input logic [31:0] x);
		logic [64:0] p;
		logic [31:0] q;
		p = 65'(x) * 65'(RECIP_101);
		q = 32'(p >> 39);
		return 7'(x - q * 32'd101);
	endfunction

	// Remainder of a word by the number of moves.
	function automatic logic [MW-1:0] mod_moves(input logic [31:0] x);
		logic [64:0] p;
		logic [31:0] q;
		p = 65'(x) * 65'(RECIP_MV);
		q = 32'(p >> (32 + LW_MV));
		return MW'(x - q * 32'(NUM_MOVES));
	endfunction

	// Draw helpers. The residues of the word that the next draw produces are
	// kept in registers, one LFSR step ahead of the generator itself.
	logic [31:0] lfsr_n, lfsr_d;
	assign lfsr_n = lfsr_next(lfsr_q);
	always_comb begin
		lfsr_d = lfsr_q;
		if (cfg_we && cfg_index == REG_RANDOM_SEED)
			lfsr_d = (cfg_data == '0) ? 32'd1 : cfg_data;
		else if (cmd.draw_grd || cmd.draw_rnd)
			lfsr_d = lfsr_n;
	end
	assign stat.greedy = (49'(d101_q) * 49'd65536) < (49'(ONE_Q16 - eps_q) * 49'd100);
	assign stat.rnd_ok = ok[cand_q];
	assign stat.draws_done = draws_q == DW'(MAX_DRAWS - 1);
	assign stat.clear_done = clr_addr_q == AW'(DEPTH - 1);
	assign stat.scan_done  = scan_m_q == MW'(NUM_MOVES);

	// Scan step: rd_q holds the entry of move scan_m_q-1.
	logic [MW-1:0] prev_m;
	assign prev_m = scan_m_q - MW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q      <= 17'd26214;
			learn_rate_q    <= 17'd58982;
			explore_decay_q <= 17'd65427;
			explore_start_q <= 17'd65536;
			initial_value_q <= 32'sd655360;
			random_seed_q   <= 32'd1;
			eps_q           <= ONE_Q16;
			lfsr_q          <= 32'd1;
			d101_q          <= 7'(FIRST_WORD % 32'd101);
			cand_q          <= MW'(FIRST_WORD % 32'(NUM_MOVES));
			cell_q          <= '0;
			old_cell_q      <= '0;
			for (int k = 0; k < NUM_COORDS; k++) coord_q[k] <= '0;
			clr_addr_q      <= '0;
			scan_m_q        <= '0;
			move_q          <= '0;
			draws_q         <= '0;
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DISCOUNT:      discount_q <= cfg_data[16:0];
					REG_LEARN_RATE:    learn_rate_q <= cfg_data[16:0];
					REG_EXPLORE_DECAY: explore_decay_q <= cfg_data[16:0];
					REG_EXPLORE_START: begin
						explore_start_q <= cfg_data[16:0];
						eps_q <= clamp_one(cfg_data[16:0]);
					end
					REG_INITIAL_VALUE: initial_value_q <= cfg_data;
					REG_RANDOM_SEED:   random_seed_q <= cfg_data;
					default: ;
				endcase
			end
			// Random generator and the residues of its next word.
			lfsr_q <= lfsr_d;
			d101_q <= mod_101(lfsr_next(lfsr_d));
			cand_q <= mod_moves(lfsr_next(lfsr_d));
			// Clearing sweep address.
			if (cmd.clear_rst) clr_addr_q <= '0;
			else if (cmd.clear_wr && !stat.clear_done) clr_addr_q <= clr_addr_q + AW'(1);
			// Decay product.
			if (cmd.start) begin
				eps_prod_q  <= 34'(eps_q) * 34'(clamp_one(explore_decay_q)) + 34'd32768;
				perf_q      <= performance;
				old_cell_q  <= cell_q;
			end
			if (cmd.scan_rst) begin
				scan_m_q <= '0;
			end else if (cmd.scan_step) begin
				scan_m_q <= scan_m_q + MW'(1);
				if (scan_m_q == MW'(1)) begin
					best_q <= rd_q;
					if (!cmd.scan_new) move_q <= '0;
				end else if (scan_m_q != '0) begin
					if (ok[prev_m] && rd_q > best_q) begin
						best_q <= rd_q;
						if (!cmd.scan_new) move_q <= prev_m;
					end
				end
			end
			// The decay result is taken in the first scan cycle.
			if (cmd.scan_step && !cmd.scan_new && scan_m_q == '0) begin
				eps_q <= clamp_one(eps_prod_q[32:16]);
			end
			// Greedy test and redraws.
			if (cmd.draw_grd) begin
				draws_q <= '0;
				if (!stat.greedy) move_q <= '0;
			end
			if (cmd.draw_rnd) begin
				draws_q <= draws_q + DW'(1);
				if (stat.rnd_ok) move_q <= cand_q;
			end
			// Apply the move.
			if (cmd.do_move) begin
				for (int k = 0; k < NUM_COORDS; k++) begin
					if (32'(move_q) == 32'(2*k+1)) coord_q[k] <= coord_q[k] + KW'(1);
					if (32'(move_q) == 32'(2*k+2)) coord_q[k] <= coord_q[k] - KW'(1);
				end
			end
			// The new cell is registered from the coordinates and follows them in the next cycle.
			cell_q <= cell_calc;
		end
	end

	// Arithmetic pipeline and result registers.
	always_ff @(posedge clk) begin
		if (cmd.mul_look) begin
			sample_q <= 38'(perf_q) - 38'(last_perf_q) + mulr(38'(best_q), clamp_one(discount_q));
		end
		if (cmd.mul_learn) begin
			nq_q <= 38'(q_old_q) + mulr(sample_q - 38'(q_old_q), clamp_one(learn_rate_q));
		end
		if (cmd.write_q) begin
			chosen_move   <= 3'(move_q);
			grid_cell     <= 4'(cell_q);
			explore_prob  <= eps_q;
			updated_value <= nq_sat;
		end
	end

	// Old Q value is read at the update address through a second read port while
	// the new cell is scanned, and captured with the gamma product.
	logic [AW-1:0] q_addr_q;
	logic signed [31:0] q_rd_q;
	always_ff @(posedge clk) begin
		q_addr_q <= wr_addr;
		q_rd_q   <= mem[q_addr_q];
		if (cmd.mul_look) q_old_q <= q_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_perf_q <= '0;
		else if (cmd.write_q) last_perf_q <= perf_q;
	end

endmodule

// ===== hdl/tabular_q_learning_step.sv =====
// ---------------------------------------------------------------------------
// Tabular Q-learning step
// One epsilon-greedy move and one value table update per performance word.
// ---------------------------------------------------------------------------
// Each accepted word takes two scans of the NUM_MOVES table entries through
// the registered memory read port, up to eight LFSR redraws, and two rounded
// multiplies in sequence. After reset, and after each write of initial_value,
// a clearing pass over all GRID_SIZE**NUM_COORDS * (1 + 2*NUM_COORDS) table
// entries runs before the next word is taken. One result word follows each
// input word.
module tabular_q_learning_step
	import tql_pkg::*;
#(
	parameter int NUM_COORDS = NUM_COORDS_DEF,
	parameter int GRID_SIZE  = GRID_SIZE_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] performance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         chosen_move,
	output logic [3:0]         grid_cell,
	output logic [16:0]        explore_prob,
	output logic signed [31:0] updated_value
);

	tql_cmd_t  cmd;
	tql_stat_t stat;
	logic      refill_q;

	// A table refill is pending after a write of the initial value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_q <= 1'b0;
		end else if (cfg_we && cfg_index == REG_INITIAL_VALUE) begin
			refill_q <= 1'b1;
		end else if (cmd.clear_wr) begin
			refill_q <= 1'b0;
		end
	end

	tql_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.refill    (refill_q || (cfg_we && cfg_index == REG_INITIAL_VALUE)),
		.cmd       (cmd),
		.stat      (stat)
	);

	tql_datapath #(
		.NUM_COORDS (NUM_COORDS),
		.GRID_SIZE  (GRID_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.performance   (performance),
		.cmd           (cmd),
		.stat          (stat),
		.chosen_move   (chosen_move),
		.grid_cell     (grid_cell),
		.explore_prob  (explore_prob),
		.updated_value (updated_value)
	);

endmodule

// ===== hdl/tql_checker.sv =====
// ---------------------------------------------------------------------------
// Q-learning step checker
// Port-level checks of the Q-learning step block.
// ---------------------------------------------------------------------------
module tql_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  chosen_move,
	input logic [16:0] explore_prob
);

	// No new word is taken while a result waits.
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// A result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chosen_move))
		else $error("result dropped");

	// An accepted word never yields a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");

	// Epsilon never exceeds one.
	a_eps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> explore_prob <= 17'd65536) else $error("epsilon above one");

endmodule

bind tabular_q_learning_step tql_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.chosen_move  (chosen_move),
	.explore_prob (explore_prob)
);
